[src/aga_pkg.sv]
// ----------------------------------------------------------------------------
// aga_pkg
// shared types, codes and constants for the anagram group assigner
// ----------------------------------------------------------------------------
package aga_pkg;

    // alphabet and field widths
    localparam int ALPHABET    = 26;
    localparam int LETTER_W    = 5;
    localparam int MEMBER_W    = 8;
    localparam int GROUP_OUT_W = 4;
    localparam int STATUS_W    = 2;

    localparam logic [MEMBER_W-1:0] MEMBER_MAX = '1;

    // default sizes
    localparam int DEF_MAX_GROUPS   = 16;
    localparam int DEF_MAX_WORD_LEN = 15;

    // depth of the queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 2;

    // action codes
    localparam logic ACTION_ADD   = 1'b0;
    localparam logic ACTION_CLEAR = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_PLACED   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

    typedef struct packed {
        logic                action;
        logic [LETTER_W-1:0] letter;
        logic                last_letter;
    } in_item_t;

    typedef struct packed {
        logic [GROUP_OUT_W-1:0] group_index;
        logic                   new_group;
        logic [MEMBER_W-1:0]    member_number;
        logic [STATUS_W-1:0]    status;
    } out_item_t;

    // control part of a command handed from front to back
    typedef struct packed {
        logic clr;
        logic too_long;
    } cmd_ctrl_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_SCAN
    } back_state_t;

endpackage

[src/anagram_group_assigner.sv]
// ----------------------------------------------------------------------------
// anagram_group_assigner
// groups lowercase words by letter histogram, one letter per item
// ----------------------------------------------------------------------------
// Letters arrive one per item and the front takes one every cycle while the
// queue has room, counting them into the word histogram; a letter code above
// z counts nothing but its last-letter flag still ends the word. A finished
// word or a clear action is queued (two entries) for the back, which reads
// the open groups from the group table one per cycle while its result
// register is free, through a registered read port, and compares each whole
// signature with the word. The lookup walks the open groups in order through
// the single table read port and ends at the first match, or once every
// open group has missed. A word that ran over MAX_WORD_LEN letters, or a
// clear, is handled without a scan. Letters of the next word keep flowing
// while the back scans, until the queue fills.
// Exactly one result item comes out per finished word; a clear gives none.
// The table has no reset: only groups already opened are ever read.
// ----------------------------------------------------------------------------
module anagram_group_assigner #(
    parameter int MAX_GROUPS   = aga_pkg::DEF_MAX_GROUPS,
    parameter int MAX_WORD_LEN = aga_pkg::DEF_MAX_WORD_LEN
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  aga_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output aga_pkg::out_item_t result
);
    import aga_pkg::*;

    // per-letter count width and signature width
    localparam int CNT_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int SIG_W  = ALPHABET * CNT_W;
    localparam int CTRL_W = $bits(cmd_ctrl_t);
    localparam int CMD_W  = CTRL_W + SIG_W;

    // front to queue
    logic             push_valid;
    logic             push_ready;
    cmd_ctrl_t        push_ctrl;
    logic [SIG_W-1:0] push_hist;

    // queue to back
    logic             pop_valid;
    logic             pop_ready;
    logic [CMD_W-1:0] pop_data;
    cmd_ctrl_t        pop_ctrl;

    assign pop_ctrl = cmd_ctrl_t'(pop_data[SIG_W +: CTRL_W]);

    // letter counting and word framing
    aga_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .CNT_W        (CNT_W),
        .SIG_W        (SIG_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (push_valid),
        .cmd_ready  (push_ready),
        .cmd_ctrl   (push_ctrl),
        .cmd_hist   (push_hist)
    );

    // decouples the letter stream from the group scan
    aga_queue #(
        .DATA_W (CMD_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  ({push_ctrl, push_hist}),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    // group scan, table update and result register
    aga_back #(
        .MAX_GROUPS   (MAX_GROUPS),
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .CNT_W        (CNT_W),
        .SIG_W        (SIG_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (pop_valid),
        .cmd_ready    (pop_ready),
        .cmd_ctrl     (pop_ctrl),
        .cmd_hist     (pop_data[SIG_W-1:0]),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[src/aga_front.sv]
// ----------------------------------------------------------------------------
// aga_front
// accepts letter items, builds the word histogram and hands finished words
// and clear commands to the queue
// ----------------------------------------------------------------------------
module aga_front #(
    parameter int MAX_WORD_LEN = aga_pkg::DEF_MAX_WORD_LEN,
    parameter int CNT_W        = $clog2(MAX_WORD_LEN + 1),
    parameter int SIG_W        = aga_pkg::ALPHABET * CNT_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  aga_pkg::in_item_t  item,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output aga_pkg::cmd_ctrl_t cmd_ctrl,
    output logic [SIG_W-1:0]   cmd_hist
);
    import aga_pkg::*;

    localparam int LEN_W = $clog2(MAX_WORD_LEN + 2);

    logic [CNT_W-1:0] hist_reg  [ALPHABET];
    logic [CNT_W-1:0] hist_upd  [ALPHABET];
    logic [CNT_W-1:0] hist_next [ALPHABET];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_upd;
    logic [LEN_W-1:0] len_next;
    logic             in_range;
    logic             word_end;
    logic             accept;

    assign item_ready = cmd_ready;
    assign accept     = item_valid && item_ready;
    assign in_range   = item.letter < LETTER_W'(ALPHABET);
    assign word_end   = (item.action == ACTION_CLEAR) || item.last_letter;
    assign cmd_valid  = item_valid && word_end;

    always_comb
    begin
        for (int i = 0; i < ALPHABET; i++)
        begin
            hist_upd[i] = hist_reg[i];
            if (in_range && (item.letter == LETTER_W'(i)) &&
                (len_reg < LEN_W'(MAX_WORD_LEN)))
            begin
                hist_upd[i] = hist_reg[i] + CNT_W'(1);
            end
        end
        len_upd = len_reg;
        if (in_range && (len_reg <= LEN_W'(MAX_WORD_LEN)))
        begin
            len_upd = len_reg + LEN_W'(1);
        end
    end

    // word state is dropped on a clear or after the last letter
    always_comb
    begin
        for (int i = 0; i < ALPHABET; i++)
        begin
            hist_next[i] = word_end ? '0 : hist_upd[i];
            cmd_hist[i*CNT_W +: CNT_W] = hist_upd[i];
        end
        len_next          = word_end ? '0 : len_upd;
        cmd_ctrl.clr      = (item.action == ACTION_CLEAR);
        cmd_ctrl.too_long = (len_upd > LEN_W'(MAX_WORD_LEN));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET; i++)
            begin
                hist_reg[i] <= '0;
            end
            len_reg <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < ALPHABET; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
            len_reg <= len_next;
        end
    end

endmodule

[src/aga_queue.sv]
// ----------------------------------------------------------------------------
// aga_queue
// small first-in first-out queue of commands between front and back
// ----------------------------------------------------------------------------
module aga_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = aga_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  logic [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output logic [DATA_W-1:0] rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[src/aga_back.sv]
// ----------------------------------------------------------------------------
// aga_back
// scans the group table for the word at the queue head, updates the table
// and registers the result item
// ----------------------------------------------------------------------------
module aga_back #(
    parameter int MAX_GROUPS   = aga_pkg::DEF_MAX_GROUPS,
    parameter int MAX_WORD_LEN = aga_pkg::DEF_MAX_WORD_LEN,
    parameter int CNT_W        = $clog2(MAX_WORD_LEN + 1),
    parameter int SIG_W        = aga_pkg::ALPHABET * CNT_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  aga_pkg::cmd_ctrl_t cmd_ctrl,
    input  logic [SIG_W-1:0]   cmd_hist,
    output logic               result_valid,
    input  logic               result_ready,
    output aga_pkg::out_item_t result
);
    import aga_pkg::*;

    localparam int GRP_W  = $clog2(MAX_GROUPS);
    localparam int USED_W = $clog2(MAX_GROUPS + 1);
    localparam int ROW_W  = MEMBER_W + SIG_W;

    // each row holds the member count above the signature
    logic [ROW_W-1:0]    table_mem [MAX_GROUPS];
    logic [ROW_W-1:0]    rdata_reg;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [USED_W-1:0]   used_reg;
    logic [USED_W-1:0]   used_next;
    logic [USED_W-1:0]   addr_reg;
    logic [USED_W-1:0]   addr_next;
    logic                pend_reg;
    logic                pend_next;
    logic [GRP_W-1:0]    pidx_reg;
    logic [GRP_W-1:0]    pidx_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    out_item_t           res_reg;
    out_item_t           res_next;

    logic                out_free;
    logic                rd_en;
    logic                wr_en;
    logic [GRP_W-1:0]    wr_addr;
    logic [ROW_W-1:0]    wr_row;
    logic [MEMBER_W-1:0] hit_count;
    logic                sig_match;

    assign out_free     = !res_valid_reg || result_ready;
    assign hit_count    = rdata_reg[SIG_W +: MEMBER_W];
    assign sig_match    = (rdata_reg[SIG_W-1:0] == cmd_hist);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        addr_next      = addr_reg;
        pend_next      = pend_reg;
        pidx_next      = pidx_reg;
        res_valid_next = result_ready ? 1'b0 : res_valid_reg;
        res_next       = res_reg;
        cmd_ready      = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = pidx_reg;
        wr_row         = {hit_count, rdata_reg[SIG_W-1:0]};

        unique case (state_reg)
            BACK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    if (cmd_ctrl.clr)
                    begin
                        cmd_ready = 1'b1;
                        used_next = '0;
                    end
                    else if (cmd_ctrl.too_long)
                    begin
                        cmd_ready      = 1'b1;
                        res_valid_next = 1'b1;
                        res_next       = '{group_index: '0, new_group: 1'b0,
                                           member_number: '0,
                                           status: STATUS_TOO_LONG};
                    end
                    else
                    begin
                        addr_next  = '0;
                        pend_next  = 1'b0;
                        state_next = BACK_SCAN;
                    end
                end
            end

            BACK_SCAN:
            begin
                if (out_free)
                begin
                    if (pend_reg && sig_match)
                    begin
                        // join the matching group
                        cmd_ready      = 1'b1;
                        wr_en          = 1'b1;
                        wr_addr        = pidx_reg;
                        wr_row         = {(hit_count == MEMBER_MAX) ? hit_count
                                                    : hit_count + MEMBER_W'(1),
                                          rdata_reg[SIG_W-1:0]};
                        res_valid_next = 1'b1;
                        res_next       = '{group_index: GROUP_OUT_W'(pidx_reg),
                                           new_group: 1'b0,
                                           member_number: hit_count,
                                           status: STATUS_PLACED};
                        state_next     = BACK_IDLE;
                    end
                    else if (!pend_reg && (addr_reg >= used_reg))
                    begin
                        // no match among the open groups
                        cmd_ready      = 1'b1;
                        res_valid_next = 1'b1;
                        state_next     = BACK_IDLE;
                        if (used_reg < USED_W'(MAX_GROUPS))
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = used_reg[GRP_W-1:0];
                            wr_row    = {MEMBER_W'(1), cmd_hist};
                            used_next = used_reg + USED_W'(1);
                            res_next  = '{group_index: GROUP_OUT_W'(used_reg),
                                          new_group: 1'b1,
                                          member_number: '0,
                                          status: STATUS_PLACED};
                        end
                        else
                        begin
                            res_next = '{group_index: '0, new_group: 1'b0,
                                         member_number: '0,
                                         status: STATUS_FULL};
                        end
                    end
                    else
                    begin
                        // read the next open group while comparing this one
                        rd_en     = (addr_reg < used_reg);
                        pend_next = rd_en;
                        pidx_next = addr_reg[GRP_W-1:0];
                        if (rd_en)
                        begin
                            addr_next = addr_reg + USED_W'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            used_reg      <= '0;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            pidx_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            pidx_reg      <= pidx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // group table, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rdata_reg <= table_mem[addr_reg[GRP_W-1:0]];
        end
    end

endmodule
